### design/tfr_pkg.sv
// tfr_pkg: types and constants shared by the frame receiver modules.
// No dependencies; every other file of the block but tfr_fifo imports this package.
`default_nettype none

package tfr_pkg;

	// Fixed field widths of the item and result beats.
	localparam int unsigned TYPE_W    = 8;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned ACC_W     = 16;
	// Byte counter and frame length: wide enough for a length of 64.
	localparam int unsigned LEN_W     = 7;

	// Depths of the job queue (one entry per buffer bank) and of the result queue.
	localparam int unsigned JOB_DEPTH = 2;
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [1:0] CFG_IDX_TYPE_LOW  = 2'd0;
	localparam logic [1:0] CFG_IDX_TYPE_HIGH = 2'd1;
	localparam logic [1:0] CFG_IDX_TIMEOUT   = 2'd2;

	// Configuration reset values.
	localparam logic [TYPE_W-1:0] TYPE_LOW_RST  = 8'd1;
	localparam logic [TYPE_W-1:0] TYPE_HIGH_RST = 8'd4;
	localparam logic [TICK_W-1:0] TIMEOUT_RST   = 16'd10000;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic              mode;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [TYPE_W-1:0] frame_type;
		logic [BYTE_W-1:0] payload_byte;
		logic [IDX_W-1:0]  byte_index;
		logic              last;
		logic              empty_frame;
	} out_item_t;

	typedef struct packed {
		logic [TYPE_W-1:0] type_low;
		logic [TYPE_W-1:0] type_high;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_regs_t;

	// One completed frame handed from the front to the back.
	typedef struct packed {
		logic [TYPE_W-1:0] frame_type;
		logic [LEN_W-1:0]  length;
		logic              bank;
	} job_t;

	// Payload buffer write from the front.
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} mem_wr_t;

endpackage

`default_nettype wire

### design/tlv_frame_receiver.sv
// tlv_frame_receiver: type-length-value frame receiver with inter-byte timeout.
// Throughput: one item (byte or tick) per cycle; full rises only while two completed
// frames, one per buffer bank, still wait to be drained. Results drain at one per cycle
// while the result queue has room; each frame passes the job queue, the registered buffer
// read and the result queue. Reset clears all control state and the configuration
// registers at once; the payload buffer is not cleared and needs no clearing pass.
`default_nettype none

module tlv_frame_receiver #(
	parameter int unsigned BUFFER_DEPTH    = 64,
	parameter int unsigned LEN_FIELD_BYTES = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Item side, seen as a queue: a beat is taken when push is high and full is low.
	input  wire logic                push,
	input  wire tfr_pkg::in_item_t   item,
	output      logic                full,
	// Result side: the oldest result waits on result while empty is low.
	output      logic                empty,
	input  wire logic                pop,
	output      tfr_pkg::out_item_t  result,
	// Configuration write channel.
	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);

	import tfr_pkg::*;

	cfg_regs_t              cfg_q;
	logic                   jq_push;
	logic                   jq_pop;
	logic                   jq_full;
	logic                   jq_empty;
	job_t                   jq_in;
	job_t                   jq_head;
	mem_wr_t                mem_wr;
	logic                   of_push;
	logic                   of_full;
	out_item_t              of_data;
	logic [OUT_CNT_W-1:0]   of_count;

	// The configuration registers are always ready. Writes must come only while the block
	// is quiet; the block does not enforce this. A write takes effect from the next beat on.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.type_low      <= TYPE_LOW_RST;
			cfg_q.type_high     <= TYPE_HIGH_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IDX_TYPE_LOW: begin
					cfg_q.type_low <= cfg_data[TYPE_W-1:0];
				end
				CFG_IDX_TYPE_HIGH: begin
					cfg_q.type_high <= cfg_data[TYPE_W-1:0];
				end
				CFG_IDX_TIMEOUT: begin
					cfg_q.timeout_ticks <= cfg_data[TICK_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The front runs the framing state machine and fills one buffer bank per frame.
	tfr_front #(
		.BUFFER_DEPTH    (BUFFER_DEPTH),
		.LEN_FIELD_BYTES (LEN_FIELD_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.jq_full  (jq_full),
		.cfg      (cfg_q),
		.job_push (jq_push),
		.job      (jq_in),
		.mem_wr   (mem_wr)
	);

	// The job queue holds one entry per bank, so its occupancy is the number of
	// banks owned by the back; the front stalls when both are taken.
	tfr_fifo #(
		.item_t (job_t),
		.DEPTH  (JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.wdata  (jq_in),
		.pop    (jq_pop),
		.rdata  (jq_head),
		.empty  (jq_empty),
		.full   (jq_full),
		.count  ()
	);

	// The back reads the buffer and forms one result beat per payload byte or empty frame.
	tfr_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.job       (jq_head),
		.job_empty (jq_empty),
		.job_pop   (jq_pop),
		.of_count  (of_count),
		.of_push   (of_push),
		.of_data   (of_data)
	);

	// Result queue: parts the drain pipeline from a consumer that stalls.
	tfr_fifo #(
		.item_t (out_item_t),
		.DEPTH  (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (of_push),
		.wdata  (of_data),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.full   (of_full),
		.count  (of_count)
	);

	// A finished frame must never arrive while both banks are still owned by the back.
	a_job_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		jq_push |-> !jq_full)
		else $error("frame job pushed into a full job queue");

	// The drain pipeline must reserve room for every beat it has in flight.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		of_push |-> !of_full)
		else $error("result beat pushed into a full result queue");

	// The marker of a zero-length frame is a lone, final beat with cleared payload.
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.empty_frame) |->
			(result.last && result.byte_index == '0 && result.payload_byte == '0))
		else $error("malformed empty-frame marker");

	// The buffer is never written while the front is stalled on a full job queue.
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		jq_full |-> !mem_wr.en)
		else $error("payload write while both buffer banks are owned by the back");

endmodule

`default_nettype wire

### design/tfr_fifo.sv
// tfr_fifo: small first-in first-out queue of register entries, any item type.
// Depends on nothing but its parameters; DEPTH must be a power of two.
`default_nettype none

module tfr_fifo #(
	parameter type         item_t = logic,
	parameter int unsigned DEPTH  = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire item_t                        wdata,
	input  wire logic                         pop,
	output      item_t                        rdata,
	output      logic                         empty,
	output      logic                         full,
	output      logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

### design/tfr_front.sv
// tfr_front: framing state machine; classifies bytes and ticks, writes payload
// into the buffer and hands completed frames on as jobs. Depends on tfr_pkg.
`default_nettype none

module tfr_front #(
	parameter int unsigned BUFFER_DEPTH    = 64,
	parameter int unsigned LEN_FIELD_BYTES = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tfr_pkg::in_item_t  item,
	output      logic               full,
	input  wire logic               jq_full,
	input  wire tfr_pkg::cfg_regs_t cfg,
	output      logic               job_push,
	output      tfr_pkg::job_t      job,
	output      tfr_pkg::mem_wr_t   mem_wr
);

	import tfr_pkg::*;

	phase_t              phase_q, phase_d;
	logic [TYPE_W-1:0]   kind_q, kind_d;
	logic [ACC_W-1:0]    len_q, len_d;
	logic [LEN_W-1:0]    cnt_q, cnt_d;
	logic [TICK_W-1:0]   ticks_q, ticks_d;
	logic                bank_q;

	logic                in_fire;
	logic                is_tick;
	logic                type_hit;
	logic [TICK_W-1:0]   tick_next;
	logic                timeout_hit;
	logic [ACC_W-1:0]    len_next;
	logic [LEN_W-1:0]    cnt_next;
	logic                len_done;
	logic                len_over;
	logic                len_zero;
	logic                pay_done;

	// Stall only when both buffer banks hold frames still being drained.
	assign full    = jq_full;
	assign in_fire = push && !full;
	assign is_tick = item.mode;

	assign type_hit    = (item.rx_byte >= cfg.type_low) && (item.rx_byte <= cfg.type_high);
	assign tick_next   = ticks_q + TICK_W'(1);
	// A timeout of zero behaves like one; a wrapped count also expires.
	assign timeout_hit = (tick_next >= cfg.timeout_ticks) || (tick_next == '0);
	assign len_next    = {len_q[ACC_W-BYTE_W-1:0], item.rx_byte};
	assign cnt_next    = cnt_q + LEN_W'(1);
	assign len_done    = (cnt_next >= LEN_W'(LEN_FIELD_BYTES));
	assign len_over    = (len_next > ACC_W'(BUFFER_DEPTH));
	assign len_zero    = (len_next == '0);
	assign pay_done    = (cnt_next >= len_q[LEN_W-1:0]);

	always_comb begin
		phase_d = phase_q;
		if (in_fire) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (!is_tick && type_hit) begin
						phase_d = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					if (is_tick) begin
						if (timeout_hit) begin
							phase_d = PH_IDLE;
						end
					end else if (len_done) begin
						phase_d = (len_over || len_zero) ? PH_IDLE : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (is_tick) begin
						if (timeout_hit) begin
							phase_d = PH_IDLE;
						end
					end else if (pay_done) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		kind_d      = kind_q;
		len_d       = len_q;
		cnt_d       = cnt_q;
		ticks_d     = ticks_q;
		job_push    = 1'b0;
		mem_wr.en   = 1'b0;
		mem_wr.bank = bank_q;
		mem_wr.addr = cnt_q[IDX_W-1:0];
		mem_wr.data = item.rx_byte;
		if (in_fire) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (!is_tick && type_hit) begin
						kind_d  = item.rx_byte;
						len_d   = '0;
						cnt_d   = '0;
						ticks_d = '0;
					end
				end
				PH_LENGTH: begin
					if (is_tick) begin
						if (timeout_hit) begin
							cnt_d   = '0;
							ticks_d = '0;
						end else begin
							ticks_d = tick_next;
						end
					end else begin
						ticks_d = '0;
						len_d   = len_next;
						cnt_d   = cnt_next;
						if (len_done) begin
							cnt_d    = '0;
							// A zero-length frame goes straight to the back as a marker.
							job_push = !len_over && len_zero;
						end
					end
				end
				PH_PAYLOAD: begin
					if (is_tick) begin
						if (timeout_hit) begin
							cnt_d   = '0;
							ticks_d = '0;
						end else begin
							ticks_d = tick_next;
						end
					end else begin
						ticks_d   = '0;
						mem_wr.en = 1'b1;
						cnt_d     = cnt_next;
						if (pay_done) begin
							cnt_d    = '0;
							job_push = 1'b1;
						end
					end
				end
				default: begin
					cnt_d   = '0;
					ticks_d = '0;
				end
			endcase
		end
	end

	always_comb begin
		job.frame_type = kind_q;
		job.length     = (phase_q == PH_PAYLOAD) ? len_q[LEN_W-1:0] : '0;
		job.bank       = bank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			ticks_q <= '0;
			bank_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			ticks_q <= ticks_d;
			if (job_push) begin
				bank_q <= !bank_q;
			end
		end
	end

endmodule

`default_nettype wire

### design/tfr_back.sv
// tfr_back: two-bank payload buffer and the drain pipeline that turns one job
// into result beats, one per cycle while the result queue has room. Depends on tfr_pkg.
`default_nettype none

module tfr_back #(
	parameter int unsigned BUFFER_DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tfr_pkg::mem_wr_t                  mem_wr,
	input  wire tfr_pkg::job_t                     job,
	input  wire logic                              job_empty,
	output      logic                              job_pop,
	input  wire logic [tfr_pkg::OUT_CNT_W-1:0]     of_count,
	output      logic                              of_push,
	output      tfr_pkg::out_item_t                of_data
);

	import tfr_pkg::*;

	localparam int unsigned AW        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int unsigned MEM_WORDS = 2 << AW;

	logic [BYTE_W-1:0]  mem_q [MEM_WORDS];
	logic [LEN_W-1:0]   idx_q;
	logic [LEN_W-1:0]   idx_next;
	logic               valid_s1;
	out_item_t          meta_s1;
	logic [BYTE_W-1:0]  rdata_s1;
	logic [OUT_CNT_W:0] fill;
	logic               room;
	logic               issue;
	logic               is_empty;
	logic               is_last;

	// Count the beat already in flight so the result queue never overflows.
	assign fill     = {1'b0, of_count} + (OUT_CNT_W + 1)'(valid_s1);
	assign room     = (fill < (OUT_CNT_W + 1)'(OUT_DEPTH));
	assign issue    = !job_empty && room;
	assign idx_next = idx_q + LEN_W'(1);
	assign is_empty = (job.length == '0);
	assign is_last  = is_empty || (idx_next == job.length);
	// The job leaves the queue, freeing its bank, once its last beat is issued.
	assign job_pop  = issue && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (job_pop) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem_q[{mem_wr.bank, mem_wr.addr[AW-1:0]}] <= mem_wr.data;
		end
		if (issue) begin
			rdata_s1             <= mem_q[{job.bank, idx_q[AW-1:0]}];
			meta_s1.frame_type   <= job.frame_type;
			meta_s1.payload_byte <= '0;
			meta_s1.byte_index   <= idx_q[IDX_W-1:0];
			meta_s1.last         <= is_last;
			meta_s1.empty_frame  <= is_empty;
		end
	end

	always_comb begin
		of_push              = valid_s1;
		of_data              = meta_s1;
		of_data.payload_byte = meta_s1.empty_frame ? '0 : rdata_s1;
	end

endmodule

`default_nettype wire

### bench/tlv_frame_checker.sv
`timescale 1ns / 100ps
// tlv_frame_checker: watches the item, result and configuration channels of the frame
// receiver, predicts the result beats and compares them. Depends on tfr_pkg.

module tlv_frame_checker #(
	parameter int unsigned BUFFER_DEPTH    = 64,
	parameter int unsigned LEN_FIELD_BYTES = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic               full,
	input  wire tfr_pkg::in_item_t  item,
	input  wire logic               empty,
	input  wire logic               pop,
	input  wire tfr_pkg::out_item_t result,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output int                      fail_count,
	output int                      outstanding,
	output logic                    frame_open
);
	import tfr_pkg::*;

	cfg_regs_t          cfg;
	phase_t             phase;
	logic [TYPE_W-1:0]  frame_kind;
	logic [ACC_W-1:0]   len_acc;
	logic [LEN_W-1:0]   byte_cnt;
	logic [TICK_W-1:0]  quiet_ticks;
	logic [BYTE_W-1:0]  payload_mem [BUFFER_DEPTH];
	out_item_t          pending_beats [$];
	int                 reported;

	function automatic string describe(input out_item_t r);
		return $sformatf("type %02h byte %02h index %0d last %0b empty %0b",
			r.frame_type, r.payload_byte, r.byte_index, r.last, r.empty_frame);
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (reported < 10) begin
			$display("%0t: mismatch: %s", $realtime, what);
			reported++;
		end
	endtask

	task automatic queue_beat(input logic [BYTE_W-1:0] data, input int idx,
			input logic is_last, input logic is_empty);
		out_item_t r;
		r.frame_type   = frame_kind;
		r.payload_byte = data;
		r.byte_index   = idx[IDX_W-1:0];
		r.last         = is_last;
		r.empty_frame  = is_empty;
		pending_beats.push_back(r);
	endtask

	task automatic drop_frame();
		phase       = PH_IDLE;
		byte_cnt    = '0;
		quiet_ticks = '0;
	endtask

	// One accepted item moves the framer on by one byte or one tick.
	task automatic advance_framer(input in_item_t it);
		logic [BYTE_W-1:0] b;
		b = it.rx_byte;
		if (it.mode) begin
			// A tick only counts inside a frame; a zero limit behaves as one tick.
			if (phase != PH_IDLE) begin
				quiet_ticks = quiet_ticks + 1'b1;
				if (quiet_ticks >= cfg.timeout_ticks || quiet_ticks == '0)
					drop_frame();
			end
		end else if (phase == PH_IDLE) begin
			if (b >= cfg.type_low && b <= cfg.type_high) begin
				frame_kind  = b;
				len_acc     = '0;
				byte_cnt    = '0;
				quiet_ticks = '0;
				phase       = PH_LENGTH;
			end
		end else if (phase == PH_LENGTH) begin
			quiet_ticks = '0;
			len_acc     = {len_acc[ACC_W-BYTE_W-1:0], b};
			byte_cnt    = byte_cnt + 1'b1;
			if (byte_cnt >= LEN_FIELD_BYTES) begin
				if (len_acc > BUFFER_DEPTH) begin
					drop_frame();
				end else if (len_acc == '0) begin
					queue_beat('0, 0, 1'b1, 1'b1);
					drop_frame();
				end else begin
					byte_cnt = '0;
					phase    = PH_PAYLOAD;
				end
			end
		end else begin
			quiet_ticks = '0;
			if (byte_cnt < BUFFER_DEPTH)
				payload_mem[byte_cnt[IDX_W-1:0]] = b;
			byte_cnt = byte_cnt + 1'b1;
			if (byte_cnt >= len_acc) begin
				for (int i = 0; i < int'(len_acc) && i < BUFFER_DEPTH; i++)
					queue_beat(payload_mem[i], i, (i + 1 == int'(len_acc)), 1'b0);
				drop_frame();
			end
		end
	endtask

	task automatic check_beat(input out_item_t got);
		out_item_t want;
		if (pending_beats.size() == 0) begin
			note_failure({"unexpected result: ", describe(got)});
		end else begin
			want = pending_beats.pop_front();
			if (got.frame_type !== want.frame_type || got.payload_byte !== want.payload_byte ||
					got.byte_index !== want.byte_index || got.last !== want.last ||
					got.empty_frame !== want.empty_frame)
				note_failure({"expected ", describe(want), ", got ", describe(got)});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.type_low      = TYPE_LOW_RST;
			cfg.type_high     = TYPE_HIGH_RST;
			cfg.timeout_ticks = TIMEOUT_RST;
			frame_kind        = '0;
			len_acc           = '0;
			drop_frame();
			pending_beats.delete();
			fail_count        = 0;
			reported          = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IDX_TYPE_LOW:  cfg.type_low      = cfg_data[TYPE_W-1:0];
					CFG_IDX_TYPE_HIGH: cfg.type_high     = cfg_data[TYPE_W-1:0];
					CFG_IDX_TIMEOUT:   cfg.timeout_ticks = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			if (push && !full)
				advance_framer(item);
			if (pop && !empty)
				check_beat(result);
		end
		outstanding = pending_beats.size();
		frame_open  = (phase != PH_IDLE);
	end

endmodule

### bench/tlv_frame_receiver_tb.sv
`timescale 1ns / 100ps
// tlv_frame_receiver_tb: stimulus and verdict for the frame receiver; checking is done by
// tlv_frame_checker beside the block. Depends on tfr_pkg and both modules.

module tlv_frame_receiver_tb;
	import tfr_pkg::*;

	// Generous bound: several times the slowest correct run, including the long stall.
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam logic        MODE_BYTE   = 1'b0;
	localparam logic        MODE_TICK   = 1'b1;
	localparam int          HOLD_CYCLES = 400;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	in_item_t    item      = '0;
	logic        full;
	logic        empty;
	logic        pop       = 1'b0;
	out_item_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_IDX_TYPE_LOW;
	logic [15:0] cfg_data  = '0;

	int          fail_count;
	int          outstanding;
	logic        frame_open;

	// Pacing controls: a steady side never idles; hold_req asks the receiver for a long stall.
	logic        tx_steady = 1'b0;
	logic        rx_steady = 1'b0;
	logic        hold_req  = 1'b0;
	int          items_sent = 0;
	int unsigned cycles     = 0;

	// The settings currently programmed, so that frames can be given a valid type.
	logic [7:0]  lo_type     = TYPE_LOW_RST;
	logic [7:0]  hi_type     = TYPE_HIGH_RST;
	logic [15:0] cur_timeout = TIMEOUT_RST;

	always #10 clk = ~clk;

	tlv_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tlv_frame_checker frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.frame_open  (frame_open)
	);

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offers one beat on the item side. Every task starts by moving to the next falling
	// edge, so push is assigned once per time step; it returns at the accepting rising edge
	// with push still high, and the next caller decides whether it stays high.
	task automatic send_beat(input logic mode_bit, input logic [BYTE_W-1:0] b);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= {mode_bit, b};
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	// A tick carries a random byte, which the block must ignore.
	task automatic send_tick();
		send_beat(MODE_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_noise();
		send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	// Brings the block to rest: an open frame is finished off with zero bytes (any byte
	// inside a frame moves it on), then every expected result is drained. The frame
	// flag is read a little after the rising edge, once the checker has taken in the
	// beat accepted there.
	task automatic settle();
		#1;
		while (frame_open) begin
			send_beat(MODE_BYTE, 8'h00);
			#1;
		end
		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [7:0] lo, input logic [7:0] hi, input logic [15:0] to);
		settle();
		cfg_write(CFG_IDX_TYPE_LOW, {8'h00, lo});
		cfg_write(CFG_IDX_TYPE_HIGH, {8'h00, hi});
		cfg_write(CFG_IDX_TIMEOUT, to);
		lo_type     = lo;
		hi_type     = hi;
		cur_timeout = to;
	endtask

	// One frame with a type from the programmed range. Most are well formed with short
	// payloads; some are empty, long, oversized, or cut short and left to time out.
	task automatic send_frame();
		int          sel;
		int          len;
		int          cut;
		logic [7:0]  kind;
		logic [15:0] len_val;
		kind = lo_type + 8'($urandom_range(0, hi_type - lo_type));
		sel  = $urandom_range(0, 99);
		if (sel < 70)
			len = $urandom_range(1, 8);
		else if (sel < 78)
			len = 0;
		else if (sel < 84)
			len = $urandom_range(9, 63);
		else if (sel < 87)
			len = 64;
		else
			len = $urandom_range(65, 65535);
		len_val = len[15:0];
		send_beat(MODE_BYTE, kind);
		if (sel >= 93) begin
			// Broken frame: up to three bytes, then silence in ticks until the timeout fires,
			// where that is short enough to reach.
			cut = $urandom_range(0, 3);
			for (int k = 0; k < cut; k++)
				send_beat(MODE_BYTE, 8'($urandom_range(0, 255)));
			if (cur_timeout <= 40)
				repeat ((cur_timeout == 0) ? 1 : cur_timeout) send_tick();
			return;
		end
		send_beat(MODE_BYTE, len_val[15:8]);
		send_beat(MODE_BYTE, len_val[7:0]);
		if (len <= 64) begin
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 19) == 0)
					send_tick();
				send_beat(MODE_BYTE, 8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 4) == 0)
			send_noise();
	endtask

	task automatic run_phase(input logic [7:0] lo, input logic [7:0] hi, input logic [15:0] to,
			input int budget, input bit squeeze);
		int stop_at;
		configure(lo, hi, to);
		stop_at = items_sent + budget;
		if (squeeze) begin
			// The receiver stops taking results while the sender streams frames back to
			// back, so the result queue and both buffer banks fill and full must rise.
			hold_req  = 1'b1;
			tx_steady = 1'b1;
		end
		while (items_sent < stop_at) begin
			if (lo > hi)
				send_noise();
			else
				send_frame();
			if (!squeeze && $urandom_range(0, 7) == 0)
				tx_steady = ~tx_steady;
		end
		tx_steady = 1'b0;
	endtask

	// Result side: random pauses between beats, steady stretches, and one long hold-off
	// on request, counted here in cycles.
	initial begin : drain
		int gap;
		@(posedge arst_n);
		forever begin
			gap = rx_steady ? 0 : $urandom_range(0, 9);
			if (hold_req) begin
				gap      = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			@(negedge clk);
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			if ($urandom_range(0, 63) == 0)
				rx_steady = ~rx_steady;
		end
	end

	initial begin : stimulus
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed beats under the reset settings (types 1 to 4, long timeout).
		send_tick();                    // a tick while idle is ignored
		send_beat(MODE_BYTE, 8'h00);    // below the type range
		send_beat(MODE_BYTE, 8'hff);    // above the type range
		send_beat(MODE_BYTE, 8'h01);    // zero length gives the empty marker
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'h04);    // two payload bytes at the value extremes
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'h02);
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'hff);
		send_beat(MODE_BYTE, 8'h02);    // length 65, one past the buffer, is dropped
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'h41);
		send_beat(MODE_BYTE, 8'h03);    // length 256 through the high length byte
		send_beat(MODE_BYTE, 8'h01);
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'h03);    // a tick inside a frame, well short of the timeout
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'h01);
		send_tick();
		send_beat(MODE_BYTE, 8'h5a);

		// Full type range and a zero timeout, which must behave as a single tick.
		configure(8'h00, 8'hff, 16'h0000);
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'h00);
		send_tick();                    // discards the open frame
		send_beat(MODE_BYTE, 8'hff);
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'h01);
		send_beat(MODE_BYTE, 8'haa);

		// Random phases across a spread of settings, the extremes among them.
		run_phase(8'h00, 8'hff, 16'd1,     60,  1'b0);
		run_phase(8'h10, 8'h10, 16'd3,     80,  1'b0);
		run_phase(8'hf0, 8'hff, 16'hffff,  80,  1'b0);
		run_phase(8'hc8, 8'h64, 16'd2,     20,  1'b0);   // empty type range: nothing starts
		run_phase(8'h01, 8'h04, 16'd6,     100, 1'b1);
		run_phase(8'h00, 8'hff, 16'd20,    100, 1'b0);

		settle();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
